FILE: hdl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URI percent decoder package
// Shared types, character codes and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_PERCENT  = 8'h25;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;

   typedef enum logic {
      CMD_DATA = 1'b0,
      CMD_END  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      HELD_NONE    = 2'd0,
      HELD_PERCENT = 2'd1,
      HELD_DIGIT   = 2'd2
   } held_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              end_of_string;
      logic              last_of_run;
   } result_type;

   function automatic logic hex_valid(input logic [BYTE_W-1:0] c);
      logic ok;
      ok = 1'b0;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [3:0] v;
      v = 4'd0;
      case (c) inside
         [8'h30:8'h39]: v = c[3:0];
         [8'h41:8'h46], [8'h61:8'h66]: v = 4'(c[2:0] + 3'd1) + 4'd8;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/upd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one URI byte or an end-of-string command.
// ----------------------------------------------------------------------------
interface upd_req_if;
   import upd_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output command, output in_byte, input ready);
   modport sink   (input valid, input command, input in_byte, output ready);
endinterface

FILE: hdl/upd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one decoded character or end marker.
// ----------------------------------------------------------------------------
interface upd_rsp_if;
   import upd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic              end_of_string;
   logic              last_of_run;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_string, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_string, input last_of_run, output ready);
endinterface

FILE: hdl/uri_percent_decoder_core.sv
`timescale 1ns / 1ps
// Latency: a request's first response is valid the cycle after it is accepted.
// Throughput: one request per cycle while each yields at most one response
// and the response side is ready; a request yielding two or three responses
// holds off requests until its last response goes, one per cycle when ready.
// Reset: nothing held, query mode and plus decoding on, response buffer empty.
// ----------------------------------------------------------------------------
// URI percent decoder core
// Decodes %XX escapes, '+' to space in query mode or per CSR, flushes at end.
// ----------------------------------------------------------------------------
module uri_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   upd_req_if.sink    req_bus,
   upd_rsp_if.source  rsp_bus,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import upd_pkg::*;

   logic                      plus_always_ff;
   held_type                  held_ff, held_in;
   logic [BYTE_W-1:0]         digit_ff, digit_in;
   logic                      query_ff, query_in;
   result_type                slot_ff [MAX_RESULTS];
   result_type                slot_in [MAX_RESULTS];
   logic [1:0]                count_ff, count_in;

   result_type                res [MAX_RESULTS];
   logic [1:0]                res_n;
   logic                      req_fire, rsp_fire;

   assign rsp_fire         = (count_ff != 2'd0) && rsp_bus.ready;
   assign req_bus.ready    = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_bus.ready);
   assign req_fire         = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = (count_ff != 2'd0);
   assign rsp_bus.out_byte      = slot_ff[0].out_byte;
   assign rsp_bus.byte_valid    = slot_ff[0].byte_valid;
   assign rsp_bus.end_of_string = slot_ff[0].end_of_string;
   assign rsp_bus.last_of_run   = slot_ff[0].last_of_run;

   // Decode one request against the held state.
   always_comb begin
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] fresh_char;
      logic              do_flush;
      logic              do_fresh;
      logic [1:0]        k;
      held_type          held_eff;

      c          = req_bus.in_byte;
      held_in    = held_ff;
      digit_in   = digit_ff;
      query_in   = query_ff;
      do_flush   = 1'b0;
      do_fresh   = 1'b0;
      k          = 2'd0;
      fresh_char = c;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end

      case (held_ff)
         HELD_PERCENT: held_eff = HELD_PERCENT;
         HELD_DIGIT:   held_eff = HELD_DIGIT;
         default:      held_eff = HELD_NONE;
      endcase

      if (req_bus.command == CMD_END) begin
         do_flush = 1'b1;
      end else begin
         case (held_eff)
            HELD_PERCENT: begin
               if (hex_valid(c)) begin
                  held_in  = HELD_DIGIT;
                  digit_in = c;
               end else begin
                  do_flush = 1'b1;
                  do_fresh = 1'b1;
               end
            end
            HELD_DIGIT: begin
               if (hex_valid(c) && hex_valid(digit_ff)) begin
                  res[0].out_byte   = {hex_value(digit_ff), hex_value(c)};
                  res[0].byte_valid = 1'b1;
                  k                 = 2'd1;
                  held_in           = HELD_NONE;
                  digit_in          = '0;
               end else begin
                  do_flush = 1'b1;
                  do_fresh = 1'b1;
               end
            end
            default: do_fresh = 1'b1;
         endcase
      end

      if (do_flush) begin
         if (held_eff == HELD_PERCENT || held_eff == HELD_DIGIT) begin
            res[0].out_byte   = CH_PERCENT;
            res[0].byte_valid = 1'b1;
            k                 = 2'd1;
         end
         if (held_eff == HELD_DIGIT) begin
            res[1].out_byte   = digit_ff;
            res[1].byte_valid = 1'b1;
            k                 = 2'd2;
         end
         held_in  = HELD_NONE;
         digit_in = '0;
      end

      if (req_bus.command == CMD_END) begin
         res[k].end_of_string = 1'b1;
         k                    = k + 2'd1;
         query_in             = 1'b0;
      end else if (do_fresh) begin
         if (c == CH_PERCENT) begin
            held_in = HELD_PERCENT;
         end else begin
            if (c == CH_QUESTION) begin
               query_in = 1'b1;
            end else if (c == CH_PLUS && (query_ff || plus_always_ff)) begin
               fresh_char = CH_SPACE;
            end
            res[k].out_byte   = fresh_char;
            res[k].byte_valid = 1'b1;
            k                 = k + 2'd1;
         end
      end

      res_n = k;
      if (k != 2'd0) begin
         res[k - 2'd1].last_of_run = 1'b1;
      end
   end

   // Load the buffer on a request, otherwise shift out one response.
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (req_fire) begin
         count_in = res_n;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_in[i] = res[i];
         end
      end else if (rsp_fire) begin
         count_in = count_ff - 2'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_always_ff <= 1'b1;
         held_ff        <= HELD_NONE;
         digit_ff       <= '0;
         query_ff       <= 1'b1;
         count_ff       <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            plus_always_ff <= csr_write_data;
         end
         if (req_fire) begin
            held_ff  <= held_in;
            digit_ff <= digit_in;
            query_ff <= query_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule
